[rtl/dist_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dist_pkg
// Shared types, constants and helpers for the daily interval schedule timer.
// ----------------------------------------------------------------------------
package dist_pkg;

   localparam int TIME_W = 17;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [TIME_W:0]   time_sum_type;
   typedef logic [2:0]        op_type;
   typedef logic [1:0]        mode_type;
   typedef logic [1:0]        csr_index_type;

   // seconds-of-day limits
   localparam time_sum_type DAY_SECONDS = time_sum_type'(86400);
   localparam time_type     LAST_SECOND = time_type'(86399);
   localparam time_type     EARLY_LIMIT = time_type'(3600);
   localparam time_type     LATE_LIMIT  = time_type'(82800);

   // command codes
   localparam op_type OP_TICK    = 3'd0;
   localparam op_type OP_ENABLE  = 3'd1;
   localparam op_type OP_DISABLE = 3'd2;
   localparam op_type OP_PAUSE   = 3'd3;
   localparam op_type OP_RESUME  = 3'd4;
   localparam op_type OP_RESET   = 3'd5;

   // schedule modes
   localparam mode_type MODE_OFF    = 2'd0;
   localparam mode_type MODE_IDLE   = 2'd1;
   localparam mode_type MODE_ACTIVE = 2'd2;
   localparam mode_type MODE_PAUSED = 2'd3;

   // register indexes
   localparam csr_index_type CSR_START_SECOND     = 2'd0;
   localparam csr_index_type CSR_DURATION_SECONDS = 2'd1;
   localparam csr_index_type CSR_REPEAT_INTERVAL  = 2'd2;

   typedef struct packed {
      time_type start_second;
      time_type duration_seconds;
      time_type repeat_interval;
   } cfg_type;

   typedef struct packed {
      logic     start_pulse;
      logic     end_pulse;
      mode_type mode_code;
      time_type next_start_second;
      time_type seconds_left;
   } rsp_type;

   // clamp a time value to the last second of the day
   function automatic time_type sat_time(input time_type value);
      sat_time = (value > LAST_SECOND) ? LAST_SECOND : value;
   endfunction

endpackage
`default_nettype wire

[rtl/dist_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dist_req_if
// Command / tick channel of the schedule timer.
// ----------------------------------------------------------------------------
interface dist_req_if;
   import dist_pkg::*;

   logic     valid;
   logic     ready;
   op_type   op;
   time_type now_second;

   modport source (output valid, output op, output now_second, input ready);
   modport sink   (input valid, input op, input now_second, output ready);
endinterface
`default_nettype wire

[rtl/dist_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dist_rsp_if
// Result channel of the schedule timer.
// ----------------------------------------------------------------------------
interface dist_rsp_if;
   import dist_pkg::*;

   logic     valid;
   logic     ready;
   logic     start_pulse;
   logic     end_pulse;
   mode_type mode_code;
   time_type next_start_second;
   time_type seconds_left;

   modport source (output valid, output start_pulse, output end_pulse, output mode_code,
                   output next_start_second, output seconds_left, input ready);
   modport sink   (input valid, input start_pulse, input end_pulse, input mode_code,
                   input next_start_second, input seconds_left, output ready);
endinterface
`default_nettype wire

[rtl/dist_csr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dist_csr_if
// Register write channel of the schedule timer.
// ----------------------------------------------------------------------------
interface dist_csr_if;
   import dist_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   time_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/daily_interval_schedule_timer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// daily_interval_schedule_timer
// Time-of-day schedule (off / idle / active / paused) driven by ticks and
// commands, one result transaction per request transaction.
// ----------------------------------------------------------------------------
// usage
//   req_chan : op (tick, enable, disable, pause, resume, reset) and now_second
//   rsp_chan : start/end pulses, mode, next start and remaining active seconds
//   csr_chan : register writes (start second, duration, repeat interval),
//              always ready; write only while no transaction is in flight
// timing
//   a request is captured into an input register; the schedule step then
//   loads the result register, which offers the response
//   one transaction per cycle sustained while rsp_chan is not stalled: the step
//   is a few 18-bit adds and compares between the input and result registers
// stall
//   while rsp_chan is stalled the result register holds; the input register
//   still takes one more request, then req_chan.ready drops
// reset
//   both registers empty, mode off, next start and active-since zero, all
//   configuration registers zero
// ----------------------------------------------------------------------------
module daily_interval_schedule_timer (
   input wire         clock,
   input wire         reset,
   dist_req_if.sink   req_chan,
   dist_rsp_if.source rsp_chan,
   dist_csr_if.sink   csr_chan
);
   import dist_pkg::*;

   // input register
   logic     in_valid_ff, in_valid_in;
   op_type   in_op_ff;
   time_type in_now_ff;

   // result register
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff;

   cfg_type  cfg;
   rsp_type  step_result;
   logic     out_free;
   logic     step_en;
   logic     req_fire;

   // result register frees when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step_en  = in_valid_ff && out_free;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || step_en;
   assign csr_chan.ready = 1'b1;

   dist_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   dist_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .op      (in_op_ff),
      .now     (in_now_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_comb begin
      in_valid_in  = req_fire || (in_valid_ff && !step_en);
      out_valid_in = step_en || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff  <= req_chan.op;
         in_now_ff <= sat_time(req_chan.now_second);
      end
      if (step_en) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.start_pulse       = out_data_ff.start_pulse;
   assign rsp_chan.end_pulse         = out_data_ff.end_pulse;
   assign rsp_chan.mode_code         = out_data_ff.mode_code;
   assign rsp_chan.next_start_second = out_data_ff.next_start_second;
   assign rsp_chan.seconds_left      = out_data_ff.seconds_left;

endmodule
`default_nettype wire

[rtl/dist_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dist_csr
// Configuration registers, saturated to the last second of the day on write.
// ----------------------------------------------------------------------------
module dist_csr (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     wr_en,
   input  dist_pkg::csr_index_type wr_index,
   input  dist_pkg::time_type      wr_data,
   output dist_pkg::cfg_type       cfg
);
   import dist_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   time_type data_sat;

   always_comb begin
      data_sat = sat_time(wr_data);
      cfg_in   = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_START_SECOND:     cfg_in.start_second     = data_sat;
            CSR_DURATION_SECONDS: cfg_in.duration_seconds = data_sat;
            CSR_REPEAT_INTERVAL:  cfg_in.repeat_interval  = data_sat;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[rtl/dist_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dist_core
// Schedule state and the per-transaction next-state / result logic.
// ----------------------------------------------------------------------------
module dist_core (
   input  wire                clock,
   input  wire                reset,
   input  wire                step_en,
   input  dist_pkg::op_type   op,
   input  dist_pkg::time_type now,
   input  dist_pkg::cfg_type  cfg,
   output dist_pkg::rsp_type  result
);
   import dist_pkg::*;

   mode_type     mode_ff, mode_in;
   time_type     next_start_ff, next_start_in;
   time_type     active_since_ff, active_since_in;

   time_sum_type end_sum;
   logic         end_wrap;
   time_type     end_low;
   logic         end_due;
   time_sum_type next_sum;
   time_type     next_mod;
   logic         start_due;
   time_type     elapsed;
   logic         start_p;
   logic         end_p;

   // end time and following start, both folded back into one day
   always_comb begin
      end_sum  = {1'b0, active_since_ff} + {1'b0, cfg.duration_seconds};
      end_wrap = (end_sum >= DAY_SECONDS);
      end_low  = end_wrap ? time_type'(end_sum - DAY_SECONDS) : time_type'(end_sum);
      end_due  = end_wrap ? ((now >= end_low) && (active_since_ff > now))
                          : (now >= end_low);
      next_sum = {1'b0, end_low} + {1'b0, cfg.repeat_interval};
      next_mod = (next_sum >= DAY_SECONDS) ? time_type'(next_sum - DAY_SECONDS)
                                            : time_type'(next_sum);
   end

   // start test with midnight handling
   always_comb begin
      if ((next_start_ff < EARLY_LIMIT) && (now > LATE_LIMIT)) begin
         start_due = 1'b0;
      end else if ((now < EARLY_LIMIT) && (next_start_ff > LATE_LIMIT)) begin
         start_due = 1'b1;
      end else begin
         start_due = (now >= next_start_ff);
      end
   end

   always_comb begin
      mode_in         = mode_ff;
      next_start_in   = next_start_ff;
      active_since_in = active_since_ff;
      start_p         = 1'b0;
      end_p           = 1'b0;
      case (op)
         OP_TICK: begin
            if (mode_ff == MODE_IDLE) begin
               if (start_due) begin
                  start_p         = 1'b1;
                  mode_in         = MODE_ACTIVE;
                  active_since_in = now;
               end
            end else if (mode_ff == MODE_ACTIVE) begin
               if (end_due) begin
                  end_p = 1'b1;
                  if (cfg.repeat_interval != '0) begin
                     mode_in       = MODE_IDLE;
                     next_start_in = next_mod;
                  end else begin
                     mode_in = MODE_OFF;
                  end
               end
            end
         end
         OP_ENABLE: begin
            if (mode_ff == MODE_OFF) begin
               mode_in       = MODE_IDLE;
               next_start_in = cfg.start_second;
            end
         end
         OP_DISABLE: begin
            end_p   = (mode_ff == MODE_ACTIVE);
            mode_in = MODE_OFF;
         end
         OP_PAUSE: begin
            if (mode_ff inside {MODE_ACTIVE, MODE_IDLE}) begin
               mode_in = MODE_PAUSED;
            end
         end
         OP_RESUME: begin
            if (mode_ff == MODE_PAUSED) begin
               mode_in = MODE_ACTIVE;
            end
         end
         OP_RESET: begin
            end_p         = (mode_ff == MODE_ACTIVE);
            mode_in       = MODE_IDLE;
            next_start_in = cfg.start_second;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // remaining active time, taken on the post-transaction state
   always_comb begin
      elapsed                  = now - active_since_in;
      result.start_pulse       = start_p;
      result.end_pulse         = end_p;
      result.mode_code         = mode_in;
      result.next_start_second = next_start_in;
      result.seconds_left      = '0;
      if ((mode_in == MODE_ACTIVE) && (now >= active_since_in) &&
          (elapsed < cfg.duration_seconds)) begin
         result.seconds_left = cfg.duration_seconds - elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_OFF;
         next_start_ff   <= '0;
         active_since_ff <= '0;
      end else if (step_en) begin
         mode_ff         <= mode_in;
         next_start_ff   <= next_start_in;
         active_since_ff <= active_since_in;
      end
   end

endmodule
`default_nettype wire

[rtl/dist_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dist_checker
// Port-level checks for the schedule timer, attached by bind.
// ----------------------------------------------------------------------------
module dist_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_ready,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire                start_pulse,
   input wire                end_pulse,
   input dist_pkg::mode_type mode_code,
   input dist_pkg::time_type next_start_second,
   input dist_pkg::time_type seconds_left
);
   import dist_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(start_pulse) &&
      $stable(end_pulse) && $stable(mode_code) && $stable(next_start_second) &&
      $stable(seconds_left))
      else $error("result changed while stalled");

   // empty pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // a start leaves the schedule active
   a_start_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_pulse |-> mode_code == MODE_ACTIVE && !end_pulse)
      else $error("start pulse without active mode");

   // an end leaves the schedule idle or off
   a_end_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && end_pulse |-> mode_code == MODE_IDLE || mode_code == MODE_OFF)
      else $error("end pulse with wrong mode");

   // remaining time only while active
   a_left_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seconds_left != '0 |-> mode_code == MODE_ACTIVE)
      else $error("remaining time outside active mode");

endmodule

bind daily_interval_schedule_timer dist_checker u_dist_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .start_pulse       (rsp_chan.start_pulse),
   .end_pulse         (rsp_chan.end_pulse),
   .mode_code         (rsp_chan.mode_code),
   .next_start_second (rsp_chan.next_start_second),
   .seconds_left      (rsp_chan.seconds_left)
);
`default_nettype wire
